// ----- design/wsfd_pkg.sv -----
// package for the websocket frame deframer
// types, codes and constants shared by every module of the block
`timescale 1ns / 1ps

package wsfd_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 64;
	localparam int unsigned REM_W           = 32;
	localparam int unsigned CNT_W           = 4;

	localparam logic [31:0]      MAX_PAYLOAD_RST = 32'd65536;
	localparam logic [7:0]       RSV_BITS        = 8'h70;
	localparam logic [6:0]       LEN16_CODE      = 7'd126;
	localparam logic [CNT_W-1:0] EXT16_BYTES     = 4'd2;
	localparam logic [CNT_W-1:0] EXT64_BYTES     = 4'd8;
	localparam logic [CNT_W-1:0] KEY_BYTES       = 4'd4;
	localparam logic [31:0]      KEY_ONES        = 32'hffff_ffff;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_RSV       = 3'd0,
		ERR_TOO_LONG  = 3'd1,
		ERR_NO_MASK   = 3'd2,
		ERR_MASK_ZERO = 3'd3,
		ERR_MASK_ONES = 3'd4
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  opcode;
		logic        fin;
		logic [63:0] payload_length;
		logic [7:0]  data_out;
		logic        last;
		err_t        error_code;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} step_t;

endpackage

// ----- design/wsfd_parser.sv -----
// frame parser: header, extended length, mask key and payload unmasking
// one byte per step; depends on wsfd_pkg
`timescale 1ns / 1ps

module wsfd_parser
	import wsfd_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  item_t       item,
	input  logic [31:0] max_payload,
	output step_t       outcome
);

	localparam int unsigned CMP_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

	typedef enum logic [2:0] {
		PH_HDR1,
		PH_HDR2,
		PH_EXT,
		PH_MASK,
		PH_PAYLOAD,
		PH_SKIP
	} phase_t;

	phase_t                 phase_q, phase_n, phase_eff;
	logic                   halted_q, halted_n;
	logic [7:0]             fhb_q, fhb_n;
	logic                   mask_q, mask_n;
	logic [CNT_W-1:0]       cnt_q, cnt_n;
	logic [LENGTH_BITS-1:0] accum_q, accum_n;
	logic                   ovf_q, ovf_n;
	logic [31:0]            key_q, key_n;
	logic [REM_W-1:0]       remain_q, remain_n;
	logic                   len_done;
	logic [7:0]             b;

	assign b = item.data_byte;

	always_comb begin
		phase_n   = phase_q;
		halted_n  = halted_q;
		fhb_n     = fhb_q;
		mask_n    = mask_q;
		cnt_n     = cnt_q;
		accum_n   = accum_q;
		ovf_n     = ovf_q;
		key_n     = key_q;
		remain_n  = remain_q;
		len_done  = 1'b0;
		outcome   = '0;
		phase_eff = item.frame_start ? PH_HDR1 : phase_q;
		if (item.frame_start) begin
			halted_n = 1'b0;
			phase_n  = PH_HDR1;
		end

		if (!halted_n) begin
			unique case (phase_eff)
				PH_HDR1: begin
					fhb_n = b;
					if ((b & RSV_BITS) != 8'd0) begin
						outcome.valid          = 1'b1;
						outcome.res.kind       = KIND_ERROR;
						outcome.res.error_code = ERR_RSV;
						halted_n               = 1'b1;
						phase_n                = PH_HDR1;
					end else begin
						phase_n = PH_HDR2;
					end
				end
				PH_HDR2: begin
					mask_n = b[7];
					ovf_n  = 1'b0;
					if (b[6:0] < LEN16_CODE) begin
						accum_n  = LENGTH_BITS'(b[6:0]);
						len_done = 1'b1;
					end else begin
						accum_n = '0;
						cnt_n   = (b[6:0] == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
						phase_n = PH_EXT;
					end
				end
				PH_EXT: begin
					// bits pushed past the top of the accumulator mean the length cannot fit
					accum_n  = {accum_q[LENGTH_BITS-9:0], b};
					ovf_n    = ovf_q || (accum_q[LENGTH_BITS-1 -: 8] != 8'd0);
					cnt_n    = cnt_q - 1'b1;
					len_done = (cnt_n == '0);
				end
				PH_MASK: begin
					key_n = {key_q[23:0], b};
					cnt_n = cnt_q - 1'b1;
					if (cnt_n == '0) begin
						if (key_n == 32'd0) begin
							outcome.valid          = 1'b1;
							outcome.res.kind       = KIND_ERROR;
							outcome.res.error_code = ERR_MASK_ZERO;
							halted_n               = 1'b1;
							phase_n                = PH_HDR1;
						end else if (key_n == KEY_ONES) begin
							outcome.valid          = 1'b1;
							outcome.res.kind       = KIND_ERROR;
							outcome.res.error_code = ERR_MASK_ONES;
							halted_n               = 1'b1;
							phase_n                = PH_HDR1;
						end else begin
							outcome.valid              = 1'b1;
							outcome.res.kind           = KIND_HEADER;
							outcome.res.opcode         = fhb_q[3:0];
							outcome.res.fin            = fhb_q[7];
							outcome.res.payload_length = 64'(accum_q);
							remain_n                   = REM_W'(accum_q);
							phase_n                    = PH_PAYLOAD;
						end
					end
				end
				PH_SKIP: begin
					cnt_n = cnt_q - 1'b1;
					if (cnt_n == '0) begin
						outcome.valid              = 1'b1;
						outcome.res.kind           = KIND_HEADER;
						outcome.res.opcode         = fhb_q[3:0];
						outcome.res.fin            = fhb_q[7];
						outcome.res.payload_length = 64'(accum_q);
						phase_n                    = PH_HDR1;
					end
				end
				PH_PAYLOAD: begin
					// key rotates so its top byte always lines up with the next byte
					outcome.valid        = 1'b1;
					outcome.res.kind     = KIND_PAYLOAD;
					outcome.res.data_out = b ^ key_q[31:24];
					key_n                = {key_q[23:0], key_q[31:24]};
					remain_n             = remain_q - 1'b1;
					if (remain_q == REM_W'(1)) begin
						outcome.res.last = 1'b1;
						phase_n          = PH_HDR1;
					end
				end
				default: begin
					phase_n = PH_HDR1;
				end
			endcase
		end

		if (len_done) begin
			// too long when length bits were lost or the limit is exceeded
			if (ovf_n || (CMP_W'(accum_n) > CMP_W'(max_payload))) begin
				outcome.valid          = 1'b1;
				outcome.res.kind       = KIND_ERROR;
				outcome.res.error_code = ERR_TOO_LONG;
				halted_n               = 1'b1;
				phase_n                = PH_HDR1;
			end else if (accum_n == '0) begin
				if (mask_n) begin
					cnt_n   = KEY_BYTES;
					phase_n = PH_SKIP;
				end else begin
					outcome.valid              = 1'b1;
					outcome.res.kind           = KIND_HEADER;
					outcome.res.opcode         = fhb_q[3:0];
					outcome.res.fin            = fhb_q[7];
					outcome.res.payload_length = 64'(accum_n);
					phase_n                    = PH_HDR1;
				end
			end else if (!mask_n) begin
				outcome.valid          = 1'b1;
				outcome.res.kind       = KIND_ERROR;
				outcome.res.error_code = ERR_NO_MASK;
				halted_n               = 1'b1;
				phase_n                = PH_HDR1;
			end else begin
				cnt_n   = KEY_BYTES;
				key_n   = '0;
				phase_n = PH_MASK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR1;
			halted_q <= 1'b0;
			fhb_q    <= '0;
			mask_q   <= 1'b0;
			cnt_q    <= '0;
			accum_q  <= '0;
			ovf_q    <= 1'b0;
			key_q    <= '0;
			remain_q <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			halted_q <= halted_n;
			fhb_q    <= fhb_n;
			mask_q   <= mask_n;
			cnt_q    <= cnt_n;
			accum_q  <= accum_n;
			ovf_q    <= ovf_n;
			key_q    <= key_n;
			remain_q <= remain_n;
		end
	end

endmodule

// ----- design/wsfd_out_stage.sv -----
// result register with valid/stall toward the receiver
// depends on wsfd_pkg
`timescale 1ns / 1ps

module wsfd_out_stage
	import wsfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  step_t   outcome,
	input  logic    result_stall,
	output logic    free,
	output logic    result_valid,
	output result_t result
);

	logic    valid_q;
	result_t result_q;

	assign free         = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load && outcome.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load && outcome.valid) begin
			result_q <= outcome.res;
		end
	end

endmodule

// ----- design/websocket_frame_deframer_unit.sv -----
// websocket client-to-server frame deframer, top level
// input register, frame parser and result register; depends on wsfd_pkg,
// wsfd_parser and wsfd_out_stage
//
// usage
//  - item channel: one stream byte per beat (data_byte, frame_start), item_valid/item_stall
//  - result channel: header, unmasked payload byte or error per beat, result_valid/result_stall
//  - cfg channel: cfg_data writes max_payload; cfg_ready is always high, write only when idle
//  - a byte with frame_start restarts the parser and clears the halt left by an error
//  - path: a byte is accepted into the input register, parsed by combinational logic, and
//    its result is captured in the result register, which drives the ports
//  - throughput: one byte per cycle while the receiver does not stall, with no gaps between
//    frames; the parse step is a single pass of logic between the input and result registers
//  - bytes that make no result (header, length, key bytes) still take a parser step each
//  - when the receiver stalls, the result register holds its beat; one more byte waits
//    in the input register, and item_stall rises only when both are occupied
//  - reset: asynchronous, clears parser state, both valid flags and sets max_payload to
//    65536; item_stall is low out of reset, so bytes are taken once reset is released
//  - LENGTH_BITS sets the width of the length accumulator; longer lengths are errors
`timescale 1ns / 1ps

module websocket_frame_deframer_unit
	import wsfd_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	// decoded results out
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	// max_payload write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic        valid_s1;
	item_t       item_s1;
	logic [31:0] max_payload_q;
	logic        free;
	logic        advance;
	step_t       outcome;

	// parser steps when the byte in the input register can move on
	assign advance    = valid_s1 && free;
	assign item_stall = valid_s1 && !free;
	assign cfg_ready  = 1'b1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	wsfd_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.max_payload(max_payload_q),
		.outcome    (outcome)
	);

	wsfd_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.outcome     (outcome),
		.result_stall(result_stall),
		.free        (free),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

// ----- design/wsfd_checker.sv -----
// port-level checks for the websocket frame deframer, bound to the top level
// depends on wsfd_pkg
`timescale 1ns / 1ps

module wsfd_checker
	import wsfd_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// stalled beat stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a fresh result must trace back to a byte accepted into the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 2))
		else $error("result without an accepted byte");

	// error beats carry only the code
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_ERROR |->
			result.payload_length == 64'd0 && result.data_out == 8'd0 && !result.last)
		else $error("error beat carries stray fields");

	// last flag only on payload beats, header beats carry no error code
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_HEADER |->
			!result.last && result.error_code == ERR_RSV && result.data_out == 8'd0)
		else $error("header beat carries stray fields");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);

// ----- tb/testbench.sv -----
// self-checking testbench for websocket_frame_deframer_unit
// drives framed byte streams under several idle patterns and max_payload settings and
// checks every result beat against an in-bench parser model; depends on wsfd_pkg
`timescale 1ns / 1ps

module testbench;
	import wsfd_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_REPORTS    = 10;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	typedef enum logic [2:0] {
		PH_HDR1, PH_HDR2, PH_EXT, PH_MASK, PH_PAYLOAD, PH_SKIP
	} parse_phase_t;

	typedef enum int {ENC_SHORT, ENC_16, ENC_64} len_enc_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	websocket_frame_deframer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// parser model state
	parse_phase_t phase_m;
	logic [31:0]  max_payload_m;
	logic [7:0]   hdr_m;
	logic         mask_m;
	logic [3:0]   left_m;
	logic [63:0]  len_m;
	logic [31:0]  key_m;
	logic [63:0]  idx_m;
	logic         halted_m;

	result_t     pending_results[$];
	logic [7:0]  frame_bytes[$];
	int          sent_bytes   = 0;
	int          fail_count   = 0;
	int          quiet_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- parser model

	task automatic push_header();
		result_t r;
		r = '0;
		r.kind           = KIND_HEADER;
		r.opcode         = hdr_m[3:0];
		r.fin            = hdr_m[7];
		r.payload_length = len_m;
		pending_results.push_back(r);
	endtask

	task automatic push_error(input err_t code);
		result_t r;
		r = '0;
		r.kind       = KIND_ERROR;
		r.error_code = code;
		halted_m = 1'b1;
		phase_m  = PH_HDR1;
		pending_results.push_back(r);
	endtask

	// length field complete: limit check, then mask handling
	task automatic finish_length();
		if (len_m > {32'd0, max_payload_m} || (len_m >> LENGTH_BITS_DEF) != 0) begin
			push_error(ERR_TOO_LONG);
		end else if (len_m == 0) begin
			if (mask_m) begin
				left_m  = KEY_BYTES;
				phase_m = PH_SKIP;
			end else begin
				phase_m = PH_HDR1;
				push_header();
			end
		end else if (!mask_m) begin
			push_error(ERR_NO_MASK);
		end else begin
			left_m  = KEY_BYTES;
			key_m   = '0;
			phase_m = PH_MASK;
		end
	endtask

	task automatic deframe_byte(input item_t it);
		logic [7:0] b;
		logic [6:0] lcode;
		int         sh;
		result_t    r;
		b = it.data_byte;
		if (it.frame_start) begin
			halted_m = 1'b0;
			phase_m  = PH_HDR1;
		end
		if (halted_m)
			return;
		case (phase_m)
			PH_HDR1: begin
				hdr_m = b;
				if ((b & RSV_BITS) != 0)
					push_error(ERR_RSV);
				else
					phase_m = PH_HDR2;
			end
			PH_HDR2: begin
				mask_m = b[7];
				lcode  = b[6:0];
				if (lcode < LEN16_CODE) begin
					len_m = 64'(lcode);
					finish_length();
				end else begin
					len_m   = '0;
					left_m  = (lcode == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
					phase_m = PH_EXT;
				end
			end
			PH_EXT: begin
				len_m  = {len_m[55:0], b};
				left_m = left_m - 1'b1;
				if (left_m == 0)
					finish_length();
			end
			PH_MASK: begin
				key_m  = {key_m[23:0], b};
				left_m = left_m - 1'b1;
				if (left_m == 0) begin
					if (key_m == 0) begin
						push_error(ERR_MASK_ZERO);
					end else if (key_m == KEY_ONES) begin
						push_error(ERR_MASK_ONES);
					end else begin
						idx_m   = '0;
						phase_m = PH_PAYLOAD;
						push_header();
					end
				end
			end
			PH_SKIP: begin
				// empty masked frame, key bytes go unchecked
				left_m = left_m - 1'b1;
				if (left_m == 0) begin
					phase_m = PH_HDR1;
					push_header();
				end
			end
			default: begin
				// key byte order follows the wire: first key byte unmasks byte 0
				sh = 8 * (3 - int'(idx_m[1:0]));
				r = '0;
				r.kind     = KIND_PAYLOAD;
				r.data_out = b ^ key_m[sh +: 8];
				idx_m = idx_m + 1;
				if (idx_m >= len_m) begin
					r.last  = 1'b1;
					phase_m = PH_HDR1;
				end
				pending_results.push_back(r);
			end
		endcase
	endtask

	// ---------------------------------------------------------------- result checking

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("unexpected result beat: kind %0d op %h fin %b len %h data %h last %b err %0d",
					got.kind, got.opcode, got.fin, got.payload_length, got.data_out,
					got.last, got.error_code);
			return;
		end
		want = pending_results.pop_front();
		if (got.kind !== want.kind || got.opcode !== want.opcode || got.fin !== want.fin ||
				got.payload_length !== want.payload_length || got.data_out !== want.data_out ||
				got.last !== want.last || got.error_code !== want.error_code) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS) begin
				$display("mismatch at %0t: expected kind %0d op %h fin %b len %h data %h last %b err %0d",
					$realtime, want.kind, want.opcode, want.fin, want.payload_length,
					want.data_out, want.last, want.error_code);
				$display("                   got kind %0d op %h fin %b len %h data %h last %b err %0d",
					got.kind, got.opcode, got.fin, got.payload_length, got.data_out,
					got.last, got.error_code);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			check_result(result);
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// any beat on any channel keeps the watchdog quiet
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus helpers

	task automatic send_byte(input logic [7:0] b, input logic fs);
		item_t it;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		it.data_byte  = b;
		it.frame_start = fs;
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sent_bytes++;
		deframe_byte(it);
	endtask

	// wait until every expected beat is back and the pipeline has emptied
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_payload(input logic [31:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		max_payload_m = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic build_frame(input logic [3:0] opc, input logic fin_b, input logic [2:0] rsv,
			input logic mask_b, input logic [63:0] ln, input len_enc_t enc,
			input logic [31:0] key, input int n_payload);
		frame_bytes.delete();
		frame_bytes.push_back({fin_b, rsv, opc});
		case (enc)
			ENC_SHORT: frame_bytes.push_back({mask_b, ln[6:0]});
			ENC_16: begin
				frame_bytes.push_back({mask_b, LEN16_CODE});
				frame_bytes.push_back(ln[15:8]);
				frame_bytes.push_back(ln[7:0]);
			end
			default: begin
				frame_bytes.push_back({mask_b, LEN64_CODE});
				for (int i = 7; i >= 0; i--)
					frame_bytes.push_back(ln[i*8 +: 8]);
			end
		endcase
		if (mask_b)
			for (int i = 3; i >= 0; i--)
				frame_bytes.push_back(key[i*8 +: 8]);
		repeat (n_payload) frame_bytes.push_back(8'($urandom));
	endtask

	task automatic drive_frame(input logic fs, input int n);
		for (int i = 0; i < n && i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], (i == 0) ? fs : 1'b0);
	endtask

	function automatic logic [63:0] pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return 64'd0;
		if (r < 75)
			return 64'($urandom_range(1, 12));
		if (r < 93)
			return 64'($urandom_range(13, 40));
		return 64'($urandom_range(126, 260));
	endfunction

	// shortest form most of the time, non-minimal encodings now and then
	function automatic len_enc_t pick_encoding(input logic [63:0] ln);
		int unsigned r;
		r = $urandom_range(99);
		if (ln < 126)
			return (r < 80) ? ENC_SHORT : ((r < 90) ? ENC_16 : ENC_64);
		if (ln <= 64'hffff)
			return (r < 85) ? ENC_16 : ENC_64;
		return ENC_64;
	endfunction

	task automatic send_random_frame();
		int unsigned cat;
		logic        fs;
		logic [3:0]  opc;
		logic        fin_b;
		logic [63:0] ln;
		logic [31:0] key;
		opc   = 4'($urandom);
		fin_b = 1'($urandom);
		ln    = pick_length();
		key   = $urandom;
		while (key == 0 || key == KEY_ONES)
			key = $urandom;
		// a parser left mid-frame or halted needs a start marker to get going
		fs  = (halted_m || phase_m != PH_HDR1) ? 1'b1 : 1'($urandom);
		cat = $urandom_range(99);
		if (cat < 70) begin
			build_frame(opc, fin_b, 3'd0, 1'b1, ln, pick_encoding(ln), key, int'(ln));
			drive_frame(fs, frame_bytes.size());
		end else if (cat < 78) begin
			// over the limit, either just past max_payload or huge
			if (max_payload_m == KEY_ONES || $urandom_range(3) == 0) begin
				ln = {32'($urandom), 32'($urandom)};
				if (ln[63:32] == 0)
					ln[63] = 1'b1;
			end else begin
				ln = 64'(max_payload_m) + 64'd1 + 64'($urandom_range(3));
			end
			build_frame(opc, fin_b, 3'd0, 1'($urandom), ln,
				(ln < 126) ? ENC_SHORT : ((ln <= 64'hffff) ? ENC_16 : ENC_64), key, 2);
			drive_frame(fs, frame_bytes.size());
		end else if (cat < 82) begin
			build_frame(opc, fin_b, 3'($urandom_range(1, 7)), 1'b1, ln, pick_encoding(ln), key, 2);
			drive_frame(fs, frame_bytes.size());
		end else if (cat < 86) begin
			if (ln == 0)
				ln = 64'd1;
			build_frame(opc, fin_b, 3'd0, 1'b0, ln, pick_encoding(ln), key, 2);
			drive_frame(fs, frame_bytes.size());
		end else if (cat < 92) begin
			// degenerate keys, only checked when the payload is not empty
			key = (cat < 89) ? 32'd0 : KEY_ONES;
			build_frame(opc, fin_b, 3'd0, 1'b1, ln, pick_encoding(ln), key, 2);
			drive_frame(fs, frame_bytes.size());
		end else if (cat < 96) begin
			// cut off mid-frame, the next frame restarts the parser
			if (ln == 0)
				ln = 64'd3;
			build_frame(opc, fin_b, 3'd0, 1'b1, ln, pick_encoding(ln), key, int'(ln));
			drive_frame(fs, $urandom_range(1, frame_bytes.size() - 1));
		end else begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom));
		end
	endtask

	task automatic run_random(input int n_bytes, input int unsigned idle, input int unsigned stall);
		int start;
		send_idle_pct = idle;
		stall_pct     = stall;
		start         = sent_bytes;
		while (sent_bytes - start < n_bytes)
			send_random_frame();
		wait_idle();
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_special_frames();
		send_idle_pct = 0;
		stall_pct     = 0;
		// reserved bits, then a byte dropped while halted
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b0);
		// empty masked ping: key bytes skipped
		build_frame(4'h9, 1'b1, 3'd0, 1'b1, 64'd0, ENC_SHORT, 32'hff00ff00, 0);
		drive_frame(1'b1, frame_bytes.size());
		// back to back, empty and unmasked, no start marker
		build_frame(4'ha, 1'b0, 3'd0, 1'b0, 64'd0, ENC_SHORT, 32'd0, 0);
		drive_frame(1'b0, frame_bytes.size());
		// longest short length without a mask
		build_frame(4'h2, 1'b1, 3'd0, 1'b0, 64'd125, ENC_SHORT, 32'd0, 0);
		drive_frame(1'b0, frame_bytes.size());
		build_frame(4'h1, 1'b1, 3'd0, 1'b1, 64'd5, ENC_SHORT, 32'd0, 0);
		drive_frame(1'b1, frame_bytes.size());
		build_frame(4'h8, 1'b1, 3'd0, 1'b1, 64'd2, ENC_16, KEY_ONES, 0);
		drive_frame(1'b1, frame_bytes.size());
		wait_idle();
	endtask

	task automatic test_reset_limit_no_idle();
		run_random(400, 0, 0);
	endtask

	task automatic test_zero_limit_sender_idle();
		set_max_payload(32'd0);
		run_random(250, 75, 0);
	endtask

	task automatic test_full_limit_receiver_stall();
		set_max_payload(KEY_ONES);
		run_random(500, 0, 75);
	endtask

	task automatic test_small_limit_both_idle();
		set_max_payload(32'd12);
		run_random(300, 6, 6);
		set_max_payload(MAX_PAYLOAD_RST);
		run_random(200, 6, 6);
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		phase_m       = PH_HDR1;
		max_payload_m = MAX_PAYLOAD_RST;
		hdr_m    = '0;
		mask_m   = 1'b0;
		left_m   = '0;
		len_m    = '0;
		key_m    = '0;
		idx_m    = '0;
		halted_m = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_special_frames();
		test_reset_limit_no_idle();
		test_zero_limit_sender_idle();
		test_full_limit_receiver_stall();
		test_small_limit_both_idle();

		wait_idle();
		if (pending_results.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
